// ===== hdl/dtrp_pkg.sv =====
// Package for the decimal token range parser: transfer payload types, status and
// sign codes, character constants and register indexes.
// No dependencies.
package dtrp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_FORMAT      = 3'd1,
    STATUS_ID_RANGE    = 3'd2,
    STATUS_VALUE_RANGE = 3'd3,
    STATUS_ODD_COUNT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_t;

  typedef enum logic [2:0] {
    REG_PAIR_MODE  = 3'd0,
    REG_MIN_FIRST  = 3'd1,
    REG_MAX_FIRST  = 3'd2,
    REG_MIN_SECOND = 3'd3,
    REG_MAX_SECOND = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       token_end;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
    logic               is_second;
  } out_item_t;

endpackage

// ===== hdl/decimal_token_range_parser.sv =====
// Decimal token range parser top level: input register, digit accumulator, range
// check, result register and APB-style register port.
// Depends on dtrp_pkg.

// The block takes one character transfer per clock cycle, back to back, unless a
// token_end transfer in the input register waits on the result register, and gives
// one result transfer for each transfer that carries token_end. The input register
// does the multiply-by-ten accumulate or the sign and range check, and the result
// register holds results. The input side keeps accepting while the result register
// is free or is being emptied, and transfers without token_end never wait on the
// result side. Register writes are meant to happen only while the block is idle.
module decimal_token_range_parser #(
  parameter int VALUE_WIDTH = dtrp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dtrp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dtrp_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtrp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dtrp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dtrp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int ACC_W = VALUE_WIDTH;
  localparam int SUM_W = VALUE_WIDTH + 4;
  localparam int CMP_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [ACC_W-1:0] POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  // Configuration registers.
  logic               pair_mode_r;
  logic signed [31:0] min_first_r;
  logic signed [31:0] max_first_r;
  logic signed [31:0] min_second_r;
  logic signed [31:0] max_second_r;

  // Input register and token state.
  logic                s1_valid_r, s1_valid_nxt;
  dtrp_pkg::in_item_t  s1_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  dtrp_pkg::sign_t     sign_r, sign_nxt;
  logic                bad_r, bad_nxt;
  logic                parity_r, parity_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  dtrp_pkg::out_item_t out_r, out_nxt;

  logic                out_free;
  logic                s1_adv;
  logic                is_digit;
  logic [3:0]          digit;
  logic [SUM_W-1:0]    acc_ext;
  logic [SUM_W-1:0]    acc_sum;
  logic signed [ACC_W-1:0] v_w;
  logic signed [CMP_W-1:0] v_cmp;
  logic signed [CMP_W-1:0] lo_cmp;
  logic signed [CMP_W-1:0] hi_cmp;
  logic                second;
  logic                cfg_wr;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!s1_r.token_end || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    acc_nxt       = acc_r;
    sign_nxt      = sign_r;
    bad_nxt       = bad_r;
    parity_nxt    = parity_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    is_digit = s1_r.ch inside {[dtrp_pkg::CH_ZERO:dtrp_pkg::CH_NINE]};
    digit    = 4'(s1_r.ch - dtrp_pkg::CH_ZERO);
    // Ten times the magnitude plus the digit; anything above the cap saturates.
    acc_ext  = SUM_W'(acc_r);
    acc_sum  = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);

    // The magnitude never exceeds the cap, so its top bit marks the cap itself.
    if (sign_r == dtrp_pkg::SIGN_MINUS) begin
      v_w = -$signed(acc_r);
    end else if (acc_r[ACC_W-1]) begin
      v_w = $signed(POS_MAX);
    end else begin
      v_w = $signed(acc_r);
    end
    v_cmp = bad_r ? '0 : CMP_W'(v_w);

    second = pair_mode_r && parity_r;
    lo_cmp = second ? CMP_W'(min_second_r) : CMP_W'(min_first_r);
    hi_cmp = second ? CMP_W'(max_second_r) : CMP_W'(max_first_r);

    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end

    if (s1_adv) begin
      if (s1_r.token_end) begin
        out_valid_nxt   = 1'b1;
        out_nxt.value   = 32'(v_cmp);
        out_nxt.is_second = parity_r;
        if (pair_mode_r && s1_r.line_end && !parity_r) begin
          out_nxt.status = dtrp_pkg::STATUS_ODD_COUNT;
        end else if (bad_r) begin
          out_nxt.status = dtrp_pkg::STATUS_FORMAT;
        end else if (v_cmp < lo_cmp || v_cmp > hi_cmp) begin
          if (second) begin
            out_nxt.status = dtrp_pkg::STATUS_VALUE_RANGE;
          end else begin
            out_nxt.status = dtrp_pkg::STATUS_ID_RANGE;
          end
        end else begin
          out_nxt.status = dtrp_pkg::STATUS_OK;
        end
        parity_nxt = s1_r.line_end ? 1'b0 : !parity_r;
        acc_nxt    = '0;
        sign_nxt   = dtrp_pkg::SIGN_NONE;
        bad_nxt    = 1'b0;
      end else if (s1_r.char_valid) begin
        if (is_digit) begin
          acc_nxt = (acc_sum > CAP_SUM) ? CAP_SUM[ACC_W-1:0] : acc_sum[ACC_W-1:0];
        end else if (s1_r.ch == dtrp_pkg::CH_PLUS || s1_r.ch == dtrp_pkg::CH_MINUS) begin
          if (sign_r != dtrp_pkg::SIGN_NONE) begin
            bad_nxt = 1'b1;
          end else if (s1_r.ch == dtrp_pkg::CH_PLUS) begin
            sign_nxt = dtrp_pkg::SIGN_PLUS;
          end else begin
            sign_nxt = dtrp_pkg::SIGN_MINUS;
          end
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sign_r      <= dtrp_pkg::SIGN_NONE;
      bad_r       <= 1'b0;
      parity_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      sign_r      <= sign_nxt;
      bad_r       <= bad_nxt;
      parity_r    <= parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // Register port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mode_r  <= 1'b0;
      min_first_r  <= 32'sh8000_0000;
      max_first_r  <= 32'sh7FFF_FFFF;
      min_second_r <= 32'sh8000_0000;
      max_second_r <= 32'sh7FFF_FFFF;
    end else if (cfg_wr) begin
      case (dtrp_pkg::reg_idx_t'(paddr[4:2]))
        dtrp_pkg::REG_PAIR_MODE:  pair_mode_r  <= pwdata[0];
        dtrp_pkg::REG_MIN_FIRST:  min_first_r  <= $signed(pwdata);
        dtrp_pkg::REG_MAX_FIRST:  max_first_r  <= $signed(pwdata);
        dtrp_pkg::REG_MIN_SECOND: min_second_r <= $signed(pwdata);
        dtrp_pkg::REG_MAX_SECOND: max_second_r <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dtrp_pkg::reg_idx_t'(paddr[4:2]))
      dtrp_pkg::REG_PAIR_MODE:  prdata = {31'd0, pair_mode_r};
      dtrp_pkg::REG_MIN_FIRST:  prdata = min_first_r;
      dtrp_pkg::REG_MAX_FIRST:  prdata = max_first_r;
      dtrp_pkg::REG_MIN_SECOND: prdata = min_second_r;
      dtrp_pkg::REG_MAX_SECOND: prdata = max_second_r;
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== tb/tb_decimal_token_range_parser.sv =====
// Self-checking testbench for decimal_token_range_parser: a directed table of tokens,
// then random token streams under several range settings, all checked field by field.
// Depends on dtrp_pkg and the decimal_token_range_parser RTL.
module tb_decimal_token_range_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam longint MAG_CAP = 64'h8000_0000;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int MAX_REPORTS = 30;
  localparam longint LIMIT_NS = 64'd10_000_000;

  typedef struct {
    dtrp_pkg::in_item_t  item;
    bit                  typed;
    dtrp_pkg::out_item_t res;
  } dir_row_t;

  logic                rst_n = 1'b0;
  logic                clk = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dtrp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dtrp_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [dtrp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [dtrp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [dtrp_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // Local copy of the parser state and its registers.
  longint             mag_acc = 0;
  dtrp_pkg::sign_t    sign_st = dtrp_pkg::SIGN_NONE;
  bit                 fmt_bad = 1'b0;
  bit                 odd_pos = 1'b0;
  bit                 cfg_pair = 1'b0;
  logic signed [31:0] cfg_lo_first = VAL_MIN;
  logic signed [31:0] cfg_hi_first = VAL_MAX;
  logic signed [31:0] cfg_lo_second = VAL_MIN;
  logic signed [31:0] cfg_hi_second = VAL_MAX;

  dtrp_pkg::out_item_t pending_results[$];
  dir_row_t  directed_rows[$];
  int        mismatch_cnt = 0;
  int        items_sent = 0;
  int        out_hold = 0;
  bit        no_idle = 1'b0;

  decimal_token_range_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("decimal_token_range_parser test failed");
    $finish;
  end

  function automatic void take_char(logic [7:0] c);
    longint d;
    if (c >= dtrp_pkg::CH_ZERO && c <= dtrp_pkg::CH_NINE) begin
      d = longint'(c - dtrp_pkg::CH_ZERO);
      if (mag_acc > (MAG_CAP - d) / 10) begin
        mag_acc = MAG_CAP;
      end else begin
        mag_acc = mag_acc * 10 + d;
      end
    end else if (c == dtrp_pkg::CH_PLUS || c == dtrp_pkg::CH_MINUS) begin
      if (sign_st != dtrp_pkg::SIGN_NONE) begin
        fmt_bad = 1'b1;
      end else if (c == dtrp_pkg::CH_PLUS) begin
        sign_st = dtrp_pkg::SIGN_PLUS;
      end else begin
        sign_st = dtrp_pkg::SIGN_MINUS;
      end
    end else begin
      fmt_bad = 1'b1;
    end
  endfunction

  // Advances the local parser by one transfer; returns 1 when a result is due.
  function automatic bit parse_step(dtrp_pkg::in_item_t it, output dtrp_pkg::out_item_t res);
    longint v;
    longint lo;
    longint hi;
    bit     second;
    res = '0;
    if (!it.token_end) begin
      if (it.char_valid) begin
        take_char(it.ch);
      end
      return 1'b0;
    end
    if (sign_st == dtrp_pkg::SIGN_MINUS) begin
      v = -mag_acc;
    end else begin
      v = (mag_acc >= MAG_CAP) ? MAG_CAP - 1 : mag_acc;
    end
    second = cfg_pair && odd_pos;
    lo = second ? longint'(cfg_lo_second) : longint'(cfg_lo_first);
    hi = second ? longint'(cfg_hi_second) : longint'(cfg_hi_first);
    if (fmt_bad) begin
      v = 0;
    end
    if (cfg_pair && it.line_end && !odd_pos) begin
      res.status = dtrp_pkg::STATUS_ODD_COUNT;
    end else if (fmt_bad) begin
      res.status = dtrp_pkg::STATUS_FORMAT;
    end else if (v < lo || v > hi) begin
      if (second) begin
        res.status = dtrp_pkg::STATUS_VALUE_RANGE;
      end else begin
        res.status = dtrp_pkg::STATUS_ID_RANGE;
      end
    end else begin
      res.status = dtrp_pkg::STATUS_OK;
    end
    res.value = v[31:0];
    res.is_second = odd_pos;
    odd_pos = it.line_end ? 1'b0 : ~odd_pos;
    mag_acc = 0;
    sign_st = dtrp_pkg::SIGN_NONE;
    fmt_bad = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  task automatic check_result(dtrp_pkg::out_item_t got);
    dtrp_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing outstanding, value", longint'(got.value),
                      longint'(0));
    end else begin
      want = pending_results.pop_front();
      if (got.value !== want.value) begin
        report_mismatch("value", longint'(got.value), longint'(want.value));
      end
      if (got.status !== want.status) begin
        report_mismatch("status", longint'(got.status), longint'(want.status));
      end
      if (got.is_second !== want.is_second) begin
        report_mismatch("is_second", longint'(got.is_second), longint'(want.is_second));
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Result side: checks each transfer and stalls at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result(out_data);
    end
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_hold <= pick_gap();
      end
    end
  end

  // Called at a rising edge; returns at the edge on which the transfer completes.
  task automatic send_item(dtrp_pkg::in_item_t it, bit typed = 1'b0,
                           dtrp_pkg::out_item_t fixed_res = '0);
    int                  gap;
    dtrp_pkg::out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (parse_step(it, res)) begin
      pending_results.push_back(typed ? fixed_res : res);
    end
    if (it.char_valid || it.token_end) begin
      items_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Character transfers produce no result but may still be in the pipeline.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(dtrp_pkg::reg_idx_t idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dtrp_pkg::REG_PAIR_MODE:  cfg_pair = data[0];
      dtrp_pkg::REG_MIN_FIRST:  cfg_lo_first = data;
      dtrp_pkg::REG_MAX_FIRST:  cfg_hi_first = data;
      dtrp_pkg::REG_MIN_SECOND: cfg_lo_second = data;
      dtrp_pkg::REG_MAX_SECOND: cfg_hi_second = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(bit pm, logic signed [31:0] lo1, logic signed [31:0] hi1,
                              logic signed [31:0] lo2, logic signed [31:0] hi2);
    write_reg(dtrp_pkg::REG_PAIR_MODE, {31'd0, pm});
    write_reg(dtrp_pkg::REG_MIN_FIRST, lo1);
    write_reg(dtrp_pkg::REG_MAX_FIRST, hi1);
    write_reg(dtrp_pkg::REG_MIN_SECOND, lo2);
    write_reg(dtrp_pkg::REG_MAX_SECOND, hi2);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c, bit cv = 1'b1, bit le = 1'b0);
    dir_row_t row;
    row.item.ch = c;
    row.item.char_valid = cv;
    row.item.token_end = 1'b0;
    row.item.line_end = le;
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_end(bit le, logic signed [31:0] v, dtrp_pkg::status_t st,
                                  bit sec);
    dir_row_t row;
    row.item.ch = 8'($urandom_range(0, 255));
    row.item.char_valid = 1'($urandom_range(0, 1));
    row.item.token_end = 1'b1;
    row.item.line_end = le;
    row.typed = 1'b1;
    row.res.value = v;
    row.res.status = st;
    row.res.is_second = sec;
    directed_rows.push_back(row);
  endfunction

  task automatic send_char(logic [7:0] c, bit cv);
    dtrp_pkg::in_item_t it;
    it.ch = c;
    it.char_valid = cv;
    it.token_end = 1'b0;
    it.line_end = ($urandom_range(0, 7) == 0);
    send_item(it);
  endtask

  // One random token: mostly well-formed digit strings with an optional sign,
  // sometimes arbitrary bytes.
  task automatic send_token();
    int                 n;
    int                 r;
    int                 sign_at;
    string              digits;
    dtrp_pkg::in_item_t it;
    digits = "";
    if ($urandom_range(0, 99) < 85) begin
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(0, 3) : (r < 95) ? $urandom_range(4, 9)
                                                     : $urandom_range(10, 12);
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: digits = "2147483647";
          1: digits = "2147483648";
          2: digits = "2147483649";
          default: digits = "4294967295";
        endcase
        n = digits.len();
      end
      sign_at = $urandom_range(0, 1) ? $urandom_range(0, n) : -1;
      for (int k = 0; k <= n; k++) begin
        if (k == sign_at) begin
          send_char($urandom_range(0, 1) ? dtrp_pkg::CH_PLUS : dtrp_pkg::CH_MINUS, 1'b1);
        end
        if (k < n) begin
          send_char((digits.len() != 0) ? digits[k]
                                        : dtrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)),
                    1'b1);
        end
        if ($urandom_range(0, 9) == 0) begin
          send_char(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 3);
        send_char((r < 2) ? 8'($urandom_range(0, 255)) :
                  (r == 2) ? dtrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)) :
                  ($urandom_range(0, 1) ? dtrp_pkg::CH_PLUS : dtrp_pkg::CH_MINUS),
                  $urandom_range(0, 7) != 0);
      end
    end
    it.ch = 8'($urandom_range(0, 255));
    it.char_valid = 1'($urandom_range(0, 1));
    it.token_end = 1'b1;
    it.line_end = ($urandom_range(0, 2) == 0);
    send_item(it);
  endtask

  initial begin
    int pair_rows_at;
    int target;

    // Reset settings: empty token, saturated negative, doubled sign, ignored
    // transfers and a sign after the digits.
    add_end(1'b0, 32'sd0, dtrp_pkg::STATUS_OK, 1'b0);
    add_char(dtrp_pkg::CH_MINUS);
    repeat (10) add_char(dtrp_pkg::CH_NINE);
    add_end(1'b0, VAL_MIN, dtrp_pkg::STATUS_OK, 1'b1);
    add_char(dtrp_pkg::CH_PLUS);
    add_char(dtrp_pkg::CH_PLUS);
    add_end(1'b0, 32'sd0, dtrp_pkg::STATUS_FORMAT, 1'b0);
    add_char(dtrp_pkg::CH_ZERO + 8'd3, 1'b0);
    add_char(8'hFF, 1'b0, 1'b1);
    add_char(dtrp_pkg::CH_ZERO + 8'd4);
    add_char(dtrp_pkg::CH_PLUS);
    add_end(1'b1, 32'sd4, dtrp_pkg::STATUS_OK, 1'b1);
    // Pair mode with an inverted second range.
    pair_rows_at = directed_rows.size();
    add_char(dtrp_pkg::CH_NINE);
    add_end(1'b0, 32'sd9, dtrp_pkg::STATUS_OK, 1'b0);
    add_char(dtrp_pkg::CH_ZERO + 8'd7);
    add_end(1'b0, 32'sd7, dtrp_pkg::STATUS_VALUE_RANGE, 1'b1);
    add_char(dtrp_pkg::CH_MINUS);
    add_char(dtrp_pkg::CH_ZERO + 8'd1);
    add_end(1'b0, -32'sd1, dtrp_pkg::STATUS_ID_RANGE, 1'b0);
    add_end(1'b1, 32'sd0, dtrp_pkg::STATUS_VALUE_RANGE, 1'b1);
    add_char(dtrp_pkg::CH_NINE + 8'd1);
    add_end(1'b1, 32'sd0, dtrp_pkg::STATUS_ODD_COUNT, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == pair_rows_at) begin
        wait_idle();
        apply_config(1'b1, 32'sd0, 32'sd9, 32'sd5, -32'sd5);
      end
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      no_idle = (ph == 3);
      case (ph)
        0: apply_config(1'b0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
        1: apply_config(1'b1, -32'sd99, 32'sd99, VAL_MIN, VAL_MAX);
        default: apply_config(1'($urandom_range(0, 1)), rand_bound(), rand_bound(),
                              rand_bound(), rand_bound());
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        send_token();
        if ($urandom_range(0, 199) == 0) begin
          wait_idle();
        end
      end
    end
    no_idle = 1'b0;
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("decimal_token_range_parser test passed");
    end else begin
      $display("decimal_token_range_parser test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dtrp_pkg.sv
hdl/decimal_token_range_parser.sv
tb/tb_decimal_token_range_parser.sv
